[hdl/ced_pkg.sv]
// ----------------------------------------------------------------------------
// ced_pkg
// Shared constants, types and state encoding of the extremum detector.
// ----------------------------------------------------------------------------
package ced_pkg;

   localparam int MAX_LAG     = 1023;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SAMPLES = 1048576;
   localparam int RING_DEPTH  = MAX_LAG + 2;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int LAG_W       = 10;
   localparam int IDX_W       = 21;
   localparam int POS_W       = 20;
   localparam int CNT_W       = 21;
   localparam int DENS_W      = 16;

   localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
   localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [RING_AW-1:0]            ring_addr_type;
   typedef logic [LAG_W-1:0]              lag_type;
   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [POS_W-1:0]              pos_type;
   typedef logic [CNT_W-1:0]              cnt_type;
   typedef logic [DENS_W-1:0]             dens_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_CALC,
      ST_DIV
   } ced_state_type;

   // density divider request and status
   typedef struct packed {
      logic    start;
      cnt_type numer;
      idx_type denom;
   } ced_div_req_type;

   typedef struct packed {
      logic     done;
      dens_type quotient;
   } ced_div_rsp_type;

endpackage

[hdl/ced_req_if.sv]
// ----------------------------------------------------------------------------
// ced_req_if
// Sample request channel: valid/ready handshake with sample payload.
// ----------------------------------------------------------------------------
interface ced_req_if;
   import ced_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);

endinterface

[hdl/ced_rsp_if.sv]
// ----------------------------------------------------------------------------
// ced_rsp_if
// Result channel: valid/ready handshake with test flags and record totals.
// ----------------------------------------------------------------------------
interface ced_rsp_if;
   import ced_pkg::*;

   logic     valid;
   logic     ready;
   pos_type  position;
   logic     tested;
   logic     is_extremum;
   logic     done_res;
   cnt_type  extremum_count;
   dens_type density;
   logic     short_record;

   modport source (output valid, position, tested, is_extremum, done_res,
                   extremum_count, density, short_record, input ready);
   modport sink   (input valid, position, tested, is_extremum, done_res,
                   extremum_count, density, short_record, output ready);

endinterface

[hdl/ced_ram.sv]
// ----------------------------------------------------------------------------
// ced_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ced_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 1025,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ced_div.sv]
// ----------------------------------------------------------------------------
// ced_div
// Restoring divider for the record density, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ced_div (
   input  logic                     clock,
   input  logic                     reset,
   input  ced_pkg::ced_div_req_type div_req,
   output ced_pkg::ced_div_rsp_type div_rsp
);
   import ced_pkg::*;

   localparam int STEP_W = $clog2(DENS_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   idx_type             rem_ff, rem_in;
   idx_type             den_ff, den_in;
   dens_type            quo_ff, quo_in;
   logic [IDX_W:0]      shifted;
   logic                fits;

   // remainder stays below the divisor, so one extra bit covers the shift
   assign shifted = {rem_ff, 1'b0};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         den_in = div_req.denom;
         if ({1'b0, div_req.numer} >= {1'b0, div_req.denom}) begin
            // quotient would reach 1.0 or more: saturate
            quo_in  = DENS_MAX;
            done_in = 1'b1;
         end else begin
            rem_in  = IDX_W'(div_req.numer);
            quo_in  = '0;
            step_in = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? IDX_W'(shifted - {1'b0, den_ff}) : IDX_W'(shifted);
         quo_in  = {quo_ff[DENS_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DENS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[hdl/coarse_grained_extremum_detector.sv]
// ----------------------------------------------------------------------------
// coarse_grained_extremum_detector
// Tests each sample position of a record against a configured lag.
// ----------------------------------------------------------------------------
// The sample history sits in a 1025-entry ring with one read port, so for
// each request y[i-1] and y[i] are read one after the other before the test
// and the write-back of the new sample, which wait for a free output. A
// last_sample request of a record that is not short then waits for the
// 16-step density divider. One response per request; the next request is
// taken while a response still waits on rsp_bus. csr_wr_data sets the lag
// and should be written only between records or while the block is idle.
// ----------------------------------------------------------------------------
module coarse_grained_extremum_detector (
   input  logic                 clock,
   input  logic                 reset,
   ced_req_if.sink              req_bus,
   ced_rsp_if.source            rsp_bus,
   input  logic                 csr_wr_en,
   input  ced_pkg::lag_type     csr_wr_data
);
   import ced_pkg::*;

   localparam logic [RING_AW:0] DEPTH_EXT = (RING_AW + 1)'(RING_DEPTH);

   ced_state_type   state_ff, state_in;
   lag_type         lag_ff;
   ring_addr_type   wptr_ff, wptr_in;
   idx_type         idx_ff, idx_in;
   cnt_type         found_ff, found_in;
   sample_type      prev_ff, prev_in;
   sample_type      sample_ff, sample_in;
   logic            last_ff, last_in;
   sample_type      yim1_ff, yim1_in;
   sample_type      yi_ff, yi_in;

   logic            rsp_valid_ff, rsp_valid_in;
   pos_type         pos_ff, pos_in;
   logic            tested_ff, tested_in;
   logic            ext_ff, ext_in;
   logic            done_ff, done_in;
   cnt_type         count_ff, count_in;
   dens_type        dens_ff, dens_in;
   logic            short_ff, short_in;

   logic [RING_AW:0] diff_i, diff_im1;
   ring_addr_type    addr_i, addr_im1, rd_addr;
   sample_type       rd_data;
   logic             ram_wr_en;

   logic            out_free, in_range, do_test, hit, short_rec;
   idx_type         len;
   cnt_type         found_next;
   ced_div_req_type div_req;
   ced_div_rsp_type div_rsp;

   // ring addresses of positions i = n-lag-1 and i-1, wrapped once
   assign diff_i   = {1'b0, wptr_ff} - (RING_AW + 1)'(lag_ff) - 1'b1;
   assign diff_im1 = {1'b0, wptr_ff} - (RING_AW + 1)'(lag_ff) - 2'd2;
   assign addr_i   = diff_i[RING_AW]   ? RING_AW'(diff_i + DEPTH_EXT)
                                       : RING_AW'(diff_i);
   assign addr_im1 = diff_im1[RING_AW] ? RING_AW'(diff_im1 + DEPTH_EXT)
                                       : RING_AW'(diff_im1);
   assign rd_addr  = (state_ff == ST_IDLE) ? addr_im1 : addr_i;

   ced_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wptr_ff),
      .wr_data (sample_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ced_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign in_range  = idx_ff < IDX_W'(MAX_SAMPLES);
   assign do_test   = in_range && (idx_ff >= IDX_W'(lag_ff) + 2'd2);
   // y[i+lag] is the previous sample, y[i+lag+1] the current one
   assign hit       = ((prev_ff > yim1_ff) && (sample_ff < yi_ff)) ||
                      ((prev_ff < yim1_ff) && (sample_ff > yi_ff));
   assign found_next = (do_test && hit && found_ff != CNT_MAX) ?
                       found_ff + 1'b1 : found_ff;
   assign len       = in_range ? idx_ff + 1'b1 : idx_ff;
   assign short_rec = len <= IDX_W'(lag_ff);

   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      prev_in      = prev_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      yim1_in      = yim1_ff;
      yi_in        = yi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      pos_in       = pos_ff;
      tested_in    = tested_ff;
      ext_in       = ext_ff;
      done_in      = done_ff;
      count_in     = count_ff;
      dens_in      = dens_ff;
      short_in     = short_ff;
      ram_wr_en    = 1'b0;
      req_bus.ready = 1'b0;
      div_req.start = 1'b0;
      div_req.numer = found_next;
      div_req.denom = len - IDX_W'(lag_ff);

      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               sample_in = req_bus.sample;
               last_in   = req_bus.last_sample;
               state_in  = ST_RD1;
            end
         end
         ST_RD1: begin
            yim1_in  = rd_data;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            yi_in    = rd_data;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (out_free) begin
               ram_wr_en = in_range;
               pos_in    = do_test ? POS_W'(idx_ff - IDX_W'(lag_ff) - 1'b1) : '0;
               tested_in = do_test;
               ext_in    = do_test && hit;
               done_in   = last_ff;
               count_in  = found_next;
               dens_in   = '0;
               short_in  = last_ff && short_rec;
               prev_in   = sample_ff;
               found_in  = found_next;
               if (in_range) begin
                  idx_in  = idx_ff + 1'b1;
                  wptr_in = (wptr_ff == RING_AW'(RING_DEPTH - 1)) ? '0
                                                                  : wptr_ff + 1'b1;
               end
               if (last_ff) begin
                  idx_in   = '0;
                  wptr_in  = '0;
                  found_in = '0;
               end
               if (last_ff && !short_rec) begin
                  div_req.start = 1'b1;
                  rsp_valid_in  = 1'b0;
                  state_in      = ST_DIV;
               end else begin
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               dens_in      = div_rsp.quotient;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lag_ff       <= LAG_W'(1);
         wptr_ff      <= '0;
         idx_ff       <= '0;
         found_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            lag_ff <= csr_wr_data;
         end
         wptr_ff      <= wptr_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_ff   <= prev_in;
      sample_ff <= sample_in;
      last_ff   <= last_in;
      yim1_ff   <= yim1_in;
      yi_ff     <= yi_in;
      pos_ff    <= pos_in;
      tested_ff <= tested_in;
      ext_ff    <= ext_in;
      done_ff   <= done_in;
      count_ff  <= count_in;
      dens_ff   <= dens_in;
      short_ff  <= short_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.position       = pos_ff;
   assign rsp_bus.tested         = tested_ff;
   assign rsp_bus.is_extremum    = ext_ff;
   assign rsp_bus.done_res       = done_ff;
   assign rsp_bus.extremum_count = count_ff;
   assign rsp_bus.density        = dens_ff;
   assign rsp_bus.short_record   = short_ff;

endmodule

[hdl/ced_checker.sv]
// ----------------------------------------------------------------------------
// ced_checker
// Port-level checks of the extremum detector, bound to the top level.
// ----------------------------------------------------------------------------
module ced_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input ced_pkg::pos_type    rsp_position,
   input logic                rsp_tested,
   input logic                rsp_is_extremum,
   input logic                rsp_done_res,
   input ced_pkg::cnt_type    rsp_extremum_count,
   input ced_pkg::dens_type   rsp_density,
   input logic                rsp_short_record
);
   import ced_pkg::*;

   // a held response keeps its position, count and density
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) &&
      $stable(rsp_extremum_count) && $stable(rsp_density))
      else $error("response changed while stalled");

   // one request in flight: the cycle after an accept takes nothing
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in work");

   // a flagged extremum comes from a test and is counted
   a_ext_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_extremum |-> rsp_tested && rsp_extremum_count != '0)
      else $error("extremum flagged without test or count");

   // short record only at record end, with zero density
   a_short_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_record |-> rsp_done_res && rsp_density == '0)
      else $error("short record flag inconsistent");

   // density is nonzero and short_record is set only on the final response
   a_dens_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_density == '0 && !rsp_short_record)
      else $error("totals shown before record end");

endmodule

bind coarse_grained_extremum_detector ced_checker u_ced_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_position       (rsp_bus.position),
   .rsp_tested         (rsp_bus.tested),
   .rsp_is_extremum    (rsp_bus.is_extremum),
   .rsp_done_res       (rsp_bus.done_res),
   .rsp_extremum_count (rsp_bus.extremum_count),
   .rsp_density        (rsp_bus.density),
   .rsp_short_record   (rsp_bus.short_record)
);

[bench/ced_extremum_checker.sv]
// ----------------------------------------------------------------------------
// ced_extremum_checker
// Watches the request, response and lag write ports of the extremum detector.
// It predicts every response from its own copy of the sample history, the
// record length, the count and the lag, and compares the responses in order.
// ----------------------------------------------------------------------------
module ced_extremum_checker (
   input  logic             clock,
   input  logic             reset,
   ced_req_if               req_mon,
   ced_rsp_if               rsp_mon,
   input  logic             csr_wr_en,
   input  ced_pkg::lag_type csr_wr_data,
   output int               fail_count,
   output int               results_seen,
   output int               records_seen,
   output int               extrema_seen,
   output int               short_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import ced_pkg::*;

   localparam lag_type LAG_AT_RESET = lag_type'(1);

   typedef struct {
      pos_type  position;
      logic     tested;
      logic     is_extremum;
      logic     done_res;
      cnt_type  extremum_count;
      dens_type density;
      logic     short_record;
   } flag_result_type;

   flag_result_type expected_flags[$];
   sample_type      sample_ring [RING_DEPTH];
   int unsigned     record_len;
   int unsigned     extremum_tally;
   lag_type         active_lag;

   int mismatches;
   int n_results;
   int n_records;
   int n_extrema;
   int n_short;

   // Advances the record state by one sample and returns the response it causes.
   function automatic flag_result_type detect_extremum(sample_type y, logic last_flag);
      flag_result_type r;
      int unsigned     n;
      int unsigned     k;
      int unsigned     i;
      int unsigned     len;
      sample_type      y_before;
      sample_type      y_at;
      sample_type      y_lead;
      longint unsigned quot;
      r = '{default: '0};
      k = active_lag;
      n = record_len;
      if (n < MAX_SAMPLES) begin
         if (n >= k + 2) begin
            i = n - k - 1;
            y_before = sample_ring[(i - 1) % RING_DEPTH];
            y_at     = sample_ring[i % RING_DEPTH];
            y_lead   = sample_ring[(n - 1) % RING_DEPTH];
            r.tested   = 1'b1;
            r.position = pos_type'(i);
            if ((y_lead > y_before && y < y_at) || (y_lead < y_before && y > y_at)) begin
               r.is_extremum = 1'b1;
               if (extremum_tally < CNT_MAX)
                  extremum_tally++;
            end
         end
         sample_ring[n % RING_DEPTH] = y;
         record_len = n + 1;
      end
      r.done_res       = last_flag;
      r.extremum_count = cnt_type'(extremum_tally);
      if (last_flag) begin
         len = record_len;
         if (len <= k) begin
            r.short_record = 1'b1;
         end else begin
            quot = (longint'(extremum_tally) << 16) / longint'(len - k);
            r.density = (quot > DENS_MAX) ? DENS_MAX : dens_type'(quot);
         end
         record_len     = 0;
         extremum_tally = 0;
      end
      return r;
   endfunction

   function automatic int field_mismatch(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      flag_result_type want;
      if (reset) begin
         expected_flags.delete();
         record_len     = 0;
         extremum_tally = 0;
         active_lag     = LAG_AT_RESET;
         mismatches     = 0;
         n_results      = 0;
         n_records      = 0;
         n_extrema      = 0;
         n_short        = 0;
      end else begin
         if (csr_wr_en)
            active_lag = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            expected_flags.push_back(detect_extremum(req_mon.sample, req_mon.last_sample));
         if (rsp_mon.valid && rsp_mon.ready) begin
            n_results++;
            if (expected_flags.size() == 0) begin
               $error("response with no request outstanding, position %0d",
                      rsp_mon.position);
               mismatches++;
            end else begin
               want = expected_flags.pop_front();
               mismatches += field_mismatch("position", want.position, rsp_mon.position);
               mismatches += field_mismatch("tested", want.tested, rsp_mon.tested);
               mismatches += field_mismatch("is_extremum", want.is_extremum,
                                            rsp_mon.is_extremum);
               mismatches += field_mismatch("done_res", want.done_res, rsp_mon.done_res);
               mismatches += field_mismatch("extremum_count", want.extremum_count,
                                            rsp_mon.extremum_count);
               mismatches += field_mismatch("density", want.density, rsp_mon.density);
               mismatches += field_mismatch("short_record", want.short_record,
                                            rsp_mon.short_record);
               if (want.done_res)
                  n_records++;
               if (want.is_extremum)
                  n_extrema++;
               if (want.short_record)
                  n_short++;
            end
         end
      end
      fail_count   <= mismatches;
      results_seen <= n_results;
      records_seen <= n_records;
      extrema_seen <= n_extrema;
      short_seen   <= n_short;
   end

endmodule

[bench/coarse_grained_extremum_detector_tb.sv]
// ----------------------------------------------------------------------------
// coarse_grained_extremum_detector_tb
// Streams sample records through the extremum detector under several lags.
// A short directed part hits the sample rails, equal neighbors, short records
// and a lag change inside a record; random records follow with random gaps
// and output stalls. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module coarse_grained_extremum_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ced_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 3;
   localparam int MAX_GAP       = 8;
   localparam int LONG_HOLD     = 150;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;

   localparam sample_type SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum int {
      SHAPE_FULL,
      SHAPE_NARROW,
      SHAPE_RAILS,
      SHAPE_RAMP
   } shape_type;

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   lag_type csr_wr_data;

   ced_req_if req_bus();
   ced_rsp_if rsp_bus();

   int fail_count;
   int results_seen;
   int records_seen;
   int extrema_seen;
   int short_seen;

   int         cycle_count;
   int         items_sent;
   bit         steady;
   bit         long_hold;
   lag_type    lag_setting;
   sample_type ramp_level;

   coarse_grained_extremum_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ced_extremum_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .records_seen (records_seen),
      .extrema_seen (extrema_seen),
      .short_seen   (short_seen)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // response side: random stall per response, one long hold when asked
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   function automatic sample_type pick_sample(shape_type shape);
      int pick;
      case (shape)
         SHAPE_NARROW: begin
            return sample_type'(int'($urandom_range(0, 2)) - 1);
         end
         SHAPE_RAILS: begin
            pick = $urandom_range(0, 2);
            return (pick == 0) ? SAMPLE_HI : (pick == 1) ? SAMPLE_LO : sample_type'(0);
         end
         SHAPE_RAMP: begin
            // rising walk; wraps now and then
            ramp_level = ramp_level + sample_type'($urandom_range(1, 64));
            return ramp_level;
         end
         default: begin
            return sample_type'($urandom);
         end
      endcase
   endfunction

   task automatic offer_sample(sample_type value, logic last_flag);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample      <= value;
      req_bus.last_sample <= last_flag;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // hold requests until every response is back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (items_sent != results_seen) @(posedge clock);
   endtask

   task automatic write_lag(lag_type value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      lag_setting = value;
   endtask

   task automatic play_record(input sample_type vals[$]);
      foreach (vals[j])
         offer_sample(vals[j], j == vals.size() - 1);
   endtask

   task automatic send_record(int len, shape_type shape, int switch_at, lag_type next_lag);
      for (int s = 0; s < len; s++) begin
         if (s == switch_at)
            write_lag(next_lag);
         offer_sample(pick_sample(shape), s == len - 1);
      end
   endtask

   initial begin
      int        random_items;
      int        phase;
      int        n_rec;
      int        len;
      int        switch_at;
      int        roll;
      lag_type   new_lag;
      lag_type   next_lag;
      shape_type shape;

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.sample      <= '0;
      req_bus.last_sample <= 1'b0;
      items_sent  = 0;
      steady      = 1'b0;
      long_hold   = 1'b0;
      lag_setting = lag_type'(1);
      ramp_level  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // lag left at its reset value; rails with equal outer pairs
      play_record('{SAMPLE_HI, SAMPLE_LO, SAMPLE_HI, SAMPLE_LO, 0, -1});
      write_lag(lag_type'(0));
      play_record('{0, 0, 1, -1, 1});
      play_record('{SAMPLE_LO});
      write_lag(lag_type'(3));
      play_record('{5, 6});
      play_record('{7, 7, 7});
      play_record('{1, 2, 3, 4});
      // lag change in the middle of a record
      write_lag(lag_type'(2));
      offer_sample(10, 1'b0);
      offer_sample(-20, 1'b0);
      offer_sample(30, 1'b0);
      write_lag(lag_type'(0));
      offer_sample(-5, 1'b0);
      offer_sample(40, 1'b0);
      offer_sample(-40, 1'b1);

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 9);
         if (phase == 0)
            new_lag = lag_type'(MAX_LAG);
         else if (roll < 4)
            new_lag = lag_type'($urandom_range(0, 3));
         else if (roll < 8)
            new_lag = lag_type'($urandom_range(4, 16));
         else if (roll == 8)
            new_lag = lag_type'($urandom_range(17, 120));
         else
            new_lag = lag_type'($urandom_range(0, MAX_LAG));
         write_lag(new_lag);
         if (phase == 2) begin
            // output held off while requests keep coming
            steady = 1'b1;
            long_hold = 1'b1;
         end
         n_rec = (phase == 0) ? 1 : $urandom_range(1, 4);
         repeat (n_rec) begin
            if (phase == 0)
               len = int'(lag_setting) + 2 + $urandom_range(0, 6);
            else if (phase == 2)
               // long enough to back up behind the held output
               len = 12 + $urandom_range(0, 12);
            else if (lag_setting > 120)
               len = $urandom_range(1, 12);
            else if ($urandom_range(0, 5) == 0)
               len = $urandom_range(1, int'(lag_setting) + 2);
            else
               len = int'(lag_setting) + 2 + $urandom_range(0, 24);
            switch_at = -1;
            if (phase != 0 && len > 2 && $urandom_range(0, 9) == 0)
               switch_at = $urandom_range(1, len - 1);
            next_lag = lag_type'($urandom_range(0, 16));
            shape = (phase == 0) ? SHAPE_FULL : shape_type'($urandom_range(0, 3));
            send_record(len, shape, switch_at, next_lag);
            random_items += len;
         end
         phase++;
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Streamed %0d samples in %0d records over lags 0 to %0d, with a lag change",
               items_sent, records_seen, MAX_LAG);
      $display("inside a record and a long output stall; %0d extrema, %0d short records.",
               extrema_seen, short_seen);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
